[design/trq_pkg.sv]
// Shared types, constants and codes for the thread run queue.
`timescale 1ns / 1ps
package trq_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ID_W     = 16;
  localparam int HANDLE_W = 8;
  localparam int FILL_W   = 5;

  typedef enum logic [1:0] {
    KIND_ENQ     = 2'd0,
    KIND_DEQ     = 2'd1,
    KIND_LOOKUP  = 2'd2,
    KIND_PROMOTE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic             compare;
    logic             commit;
    kind_t            kind;
    logic [CNT_W-1:0] count;
    entry_t           op;
  } cell_ctrl_t;

endpackage

[design/trq_req_if.sv]
// Request channel: one queue operation per transfer.
`timescale 1ns / 1ps
interface trq_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [trq_pkg::ID_W-1:0]     thread_id;
  logic [trq_pkg::HANDLE_W-1:0] handle;

  modport source (output valid, kind, thread_id, handle, input ready);
  modport sink   (input valid, kind, thread_id, handle, output ready);
endinterface

[design/trq_rsp_if.sv]
// Response channel: one result per operation.
`timescale 1ns / 1ps
interface trq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [trq_pkg::ID_W-1:0]     result_id;
  logic [trq_pkg::HANDLE_W-1:0] result_handle;
  logic                         is_empty;
  logic [trq_pkg::FILL_W-1:0]   fill;

  modport source (output valid, status, result_id, result_handle, is_empty, fill,
                  input ready);
  modport sink   (input valid, status, result_id, result_handle, is_empty, fill,
                  output ready);
endinterface

[design/trq_cell.sv]
// One queue slot: holds an entry, compares it, and shifts with its neighbors.
`timescale 1ns / 1ps
module trq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [trq_pkg::IDX_W-1:0] idx,
  input  trq_pkg::cell_ctrl_t       ctrl,
  input  trq_pkg::entry_t           prev_entry,
  input  trq_pkg::entry_t           next_entry,
  input  trq_pkg::entry_t           promo_entry,
  input  logic                      found,
  input  logic                      seen_in,
  input  trq_pkg::entry_t           sel_in,
  output trq_pkg::entry_t           entry,
  output logic                      seen_out,
  output trq_pkg::entry_t           sel_out
);
  import trq_pkg::*;

  entry_t           data;
  entry_t           data_next;
  logic             hit;
  logic             first;
  logic [CNT_W-1:0] pos;
  logic             occupied;

  assign pos      = CNT_W'(idx);
  assign occupied = (pos < ctrl.count);
  assign entry    = data;

  // Pass the match chain: first hit nearest the head wins.
  assign first    = hit && !seen_in;
  assign seen_out = seen_in || hit;
  assign sel_out  = first ? data : sel_in;

  // Pick the slot content for the commit cycle.
  always_comb begin
    data_next = data;
    case (ctrl.kind)
      KIND_ENQ: begin
        if (pos == ctrl.count) begin
          data_next = ctrl.op;
        end
      end
      KIND_DEQ: begin
        if (ctrl.count != '0) begin
          data_next = next_entry;
        end
      end
      KIND_PROMOTE: begin
        if (found && !seen_in) begin
          data_next = (idx == '0) ? promo_entry : prev_entry;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // Hold the slot; update on commit.
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      data <= data_next;
    end
  end

  // Capture the compare result in the match state, ahead of commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.compare) begin
      hit <= occupied && (data.id == ctrl.op.id);
    end
  end

endmodule

[design/thread_run_queue_promote_core.sv]
// Top level: bounded thread run queue with lookup and promote-to-head.
//
//   channel | dir | payload                                          | transfer
//   req     | in  | kind, thread_id, handle                          | valid & ready
//   rsp     | out | status, result_id, result_handle, is_empty, fill | valid & ready
//
// Each operation goes through three steps: accept, compare in every cell, commit.
// The commit cycle waits while a previous result still sits unread in rsp.
// A new request is accepted while a finished result waits to be taken.
// Reset (rst, synchronous) empties the queue; slot contents are left as is.
`timescale 1ns / 1ps
module thread_run_queue_promote_core (
  input logic      clk,
  input logic      rst,
  trq_req_if.sink  req,
  trq_rsp_if.source rsp
);
  import trq_pkg::*;

  state_t              state;
  state_t              state_next;
  kind_t               op_kind;
  entry_t              op_entry;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  cell_ctrl_t          ctrl;
  logic                do_compare;
  logic                do_commit;
  logic                out_valid;
  status_t             out_status;
  status_t             status_next;
  entry_t              out_entry;
  entry_t              result_next;
  logic                out_empty;
  logic [FILL_W-1:0]   out_fill;

  entry_t              cell_entry [DEPTH];
  logic                seen       [DEPTH+1];
  entry_t              sel        [DEPTH+1];
  entry_t              found_entry;
  logic                found;

  assign seen[0]     = 1'b0;
  assign sel[0]      = '0;
  assign found       = seen[DEPTH];
  assign found_entry = sel[DEPTH];

  // Row of slots, head at index zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    if (i == 0) begin : g_head
      assign prev_e = '0;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_e = cell_entry[i];
    end else begin : g_body
      assign next_e = cell_entry[i+1];
    end
    trq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .idx         (IDX_W'(i)),
      .ctrl        (ctrl),
      .prev_entry  (prev_e),
      .next_entry  (next_e),
      .promo_entry (found_entry),
      .found       (found),
      .seen_in     (seen[i]),
      .sel_in      (sel[i]),
      .entry       (cell_entry[i]),
      .seen_out    (seen[i+1]),
      .sel_out     (sel[i+1])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    req.ready  = 1'b0;
    do_compare = 1'b0;
    do_commit  = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = !rst;
      end
      S_MATCH: begin
        do_compare = 1'b1;
      end
      S_COMMIT: begin
        do_commit = !out_valid || rsp.ready;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign ctrl.compare = do_compare;
  assign ctrl.commit  = do_commit;
  assign ctrl.kind    = op_kind;
  assign ctrl.count   = count;
  assign ctrl.op      = op_entry;

  // Work out the result and the new fill.
  always_comb begin
    status_next = ST_OK;
    result_next = '0;
    count_next  = count;
    case (op_kind)
      KIND_ENQ: begin
        if (count == CNT_W'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      KIND_DEQ: begin
        if (count == '0) begin
          status_next = ST_MISS;
        end else begin
          result_next = cell_entry[0];
          count_next  = count - 1'b1;
        end
      end
      KIND_LOOKUP, KIND_PROMOTE: begin
        if (found) begin
          result_next = found_entry;
        end else begin
          status_next = ST_MISS;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the request and the result payload.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_kind         <= kind_t'(req.kind);
      op_entry.id     <= req.thread_id;
      op_entry.handle <= req.handle;
    end
    if (do_commit) begin
      out_status <= status_next;
      out_entry  <= result_next;
      out_empty  <= (count_next == '0);
      out_fill   <= FILL_W'(count_next);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.result_id     = out_entry.id;
  assign rsp.result_handle = out_entry.handle;
  assign rsp.is_empty      = out_empty;
  assign rsp.fill          = out_fill;

endmodule
